[hdl/indexed_list_insert_delete_assert.svh]
// Assertion macros for the indexed list block.
// Used inside the top level, which provides clk_i and rst_ni.
`ifndef INDEXED_LIST_INSERT_DELETE_ASSERT_SVH
`define INDEXED_LIST_INSERT_DELETE_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define ILID_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A consequent that must hold in the cycle after the antecedent.
`define ILID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/ilid_pkg.sv]
// Package for the indexed list block: field widths, operation and status codes,
// and the sequencer state type. No dependencies.
`default_nettype none

package ilid_pkg;

  localparam int unsigned MODE_W  = 2;
  localparam int unsigned POS_W   = 9;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned DATA_W  = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_READ   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_READ,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

[hdl/indexed_list_insert_delete.sv]
// Indexed list: insert, delete and read of signed 32-bit entries in an on-chip
// memory of CAPACITY words, one item in work at a time. A read passes through
// S_READ and S_DONE from its transfer to the result register. An insert or delete
// moves every entry behind the position through the single memory port pair, one
// entry per cycle. A refused operation goes straight to S_DONE. The next item is
// taken once the previous result sits in the output register. Depends on ilid_pkg
// and the assertion macro header.
`default_nettype none

module indexed_list_insert_delete #(
  parameter int unsigned CAPACITY = 256
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  wire  [ilid_pkg::MODE_W-1:0]         mode_i,
  input  wire  [ilid_pkg::POS_W-1:0]          position_i,
  input  wire  signed [ilid_pkg::DATA_W-1:0]  value_i,
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output ilid_pkg::status_e                   status_o,
  output logic [ilid_pkg::COUNT_W-1:0]        count_o,
  output logic signed [ilid_pkg::DATA_W-1:0]  read_value_o
);

  import ilid_pkg::*;

  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam int unsigned LenW  = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW  = ((LenW > POS_W) ? LenW : POS_W) + 1;

  logic [DATA_W-1:0] mem [CAPACITY];

  state_e             state_q, state_d;
  logic [LenW-1:0]    len_q, len_d;
  logic               more_q, more_d;
  logic               pw_valid_q, pw_valid_d;
  logic [AddrW-1:0]   pw_addr_q, pw_addr_d;
  logic [AddrW-1:0]   src_q, src_d;
  logic [AddrW-1:0]   pos_q, pos_d;
  logic [DATA_W-1:0]  val_q, val_d;
  logic               is_ins_q, is_ins_d;
  status_e            res_status_q, res_status_d;
  logic               res_rv_q, res_rv_d;
  logic [DATA_W-1:0]  rdata_q;

  logic               out_valid_q;
  status_e            out_status_q;
  logic [COUNT_W-1:0] out_count_q;
  logic [DATA_W-1:0]  out_value_q;

  logic               accept;
  logic               done_load;
  logic               rd_en;
  logic [AddrW-1:0]   raddr;
  logic               we;
  logic [AddrW-1:0]   waddr;
  logic [DATA_W-1:0]  wdata;

  logic [CmpW-1:0]    pos_ext;
  logic [CmpW-1:0]    len_ext;
  logic               full;
  status_e            dec_status;
  logic               dec_shift;
  logic               dec_read;

  assign accept    = in_valid_i && (state_q == S_IDLE);
  assign done_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  assign pos_ext   = CmpW'(position_i);
  assign len_ext   = CmpW'(len_q);
  assign full      = (len_q == LenW'(CAPACITY));

  always_comb begin
    dec_status = ST_DONE;
    dec_shift  = 1'b0;
    dec_read   = 1'b0;
    unique case (mode_e'(mode_i))
      MODE_INSERT: begin
        if (pos_ext > len_ext) begin
          dec_status = ST_RANGE;
        end else if (full) begin
          dec_status = ST_FULL;
        end else begin
          dec_shift = 1'b1;
        end
      end
      MODE_DELETE: begin
        if (pos_ext >= len_ext) begin
          dec_status = ST_RANGE;
        end else begin
          dec_shift = 1'b1;
        end
      end
      MODE_READ: begin
        if (pos_ext >= len_ext) begin
          dec_status = ST_RANGE;
        end else begin
          dec_read = 1'b1;
        end
      end
      default: begin
        dec_status = ST_DONE;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (dec_shift) begin
            state_d = S_SHIFT;
          end else if (dec_read) begin
            state_d = S_READ;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_SHIFT: begin
        if (!more_q && !pw_valid_q) begin
          state_d = S_DONE;
        end
      end
      S_READ: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (done_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    len_d        = len_q;
    more_d       = more_q;
    pw_valid_d   = 1'b0;
    pw_addr_d    = pw_addr_q;
    src_d        = src_q;
    pos_d        = pos_q;
    val_d        = val_q;
    is_ins_d     = is_ins_q;
    res_status_d = res_status_q;
    res_rv_d     = res_rv_q;
    rd_en        = 1'b0;
    raddr        = src_q;
    we           = 1'b0;
    waddr        = pw_addr_q;
    wdata        = rdata_q;
    in_stall_o   = (state_q != S_IDLE);

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          is_ins_d     = (mode_i == MODE_INSERT);
          pos_d        = AddrW'(position_i);
          val_d        = value_i;
          res_status_d = dec_status;
          res_rv_d     = dec_read;
          more_d       = 1'b0;
          if (dec_shift) begin
            if (mode_i == MODE_INSERT) begin
              src_d  = AddrW'(len_q - LenW'(1));
              more_d = (len_ext > pos_ext);
            end else begin
              src_d  = AddrW'(pos_ext + CmpW'(1));
              more_d = ((pos_ext + CmpW'(1)) < len_ext);
            end
          end
          if (dec_read) begin
            rd_en = 1'b1;
            raddr = AddrW'(position_i);
          end
        end
      end
      S_SHIFT: begin
        if (pw_valid_q) begin
          we    = 1'b1;
          waddr = pw_addr_q;
          wdata = rdata_q;
        end
        if (more_q) begin
          rd_en      = 1'b1;
          raddr      = src_q;
          pw_valid_d = 1'b1;
          if (is_ins_q) begin
            pw_addr_d = src_q + AddrW'(1);
            src_d     = src_q - AddrW'(1);
            more_d    = (src_q != pos_q);
          end else begin
            pw_addr_d = src_q - AddrW'(1);
            src_d     = src_q + AddrW'(1);
            more_d    = ((LenW'(src_q) + LenW'(1)) != len_q);
          end
        end
        if (!more_q && !pw_valid_q) begin
          if (is_ins_q) begin
            we    = 1'b1;
            waddr = pos_q;
            wdata = val_q;
            len_d = len_q + LenW'(1);
          end else begin
            len_d = len_q - LenW'(1);
          end
        end
      end
      S_READ: begin
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      more_q      <= 1'b0;
      pw_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      len_q      <= len_d;
      more_q     <= more_d;
      pw_valid_q <= pw_valid_d;
      if (done_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pw_addr_q    <= pw_addr_d;
    src_q        <= src_d;
    pos_q        <= pos_d;
    val_q        <= val_d;
    is_ins_q     <= is_ins_d;
    res_status_q <= res_status_d;
    res_rv_q     <= res_rv_d;
    if (done_load) begin
      out_status_q <= res_status_q;
      out_count_q  <= COUNT_W'(len_q);
      out_value_q  <= res_rv_q ? rdata_q : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign count_o      = out_count_q;
  assign read_value_o = out_value_q;

`include "indexed_list_insert_delete_assert.svh"

  `ILID_ASSERT_ALWAYS(a_len_in_cap, len_q <= LenW'(CAPACITY), "List length exceeds capacity.")
  `ILID_ASSERT_ALWAYS(a_pw_in_shift, !pw_valid_q || (state_q == S_SHIFT), "Pending write outside a shift.")
  `ILID_ASSERT_NEXT(a_len_only_shift, state_q != S_SHIFT, $stable(len_q), "Length changed outside a shift.")
  `ILID_ASSERT_NEXT(a_idle_clean, state_q == S_IDLE, !pw_valid_q, "Pending write after idle.")

endmodule

`default_nettype wire
